FILE: rtl/core/pal_pkg.sv
`default_nettype none

package pal_pkg;

    // List size and derived widths
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int NAME_W   = 64;
    localparam int VALUE_W  = 32;
    localparam int ST_W     = 2;
    localparam int EC_W     = 7;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic holding;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/pal_ctrl.sv
`default_nettype none

module pal_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire pal_pkg::t_dp_stat i_stat,
    output pal_pkg::t_cmd          o_cmd,
    output logic                   o_busy,
    output logic                   o_done
);
    import pal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    // Advance on an accepted request, return to idle after the execute state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC) && i_stat.holding;
        end
    end

    // Drive commands
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_busy     = (r_state == S_EXEC);
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: rtl/core/pal_dpath.sv
`default_nettype none

module pal_dpath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pal_pkg::t_cmd            i_cmd,
    input  wire logic [pal_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [pal_pkg::POS_W-1:0]   i_position,
    input  wire logic [pal_pkg::NAME_W-1:0]  i_entry_name,
    input  wire logic [pal_pkg::VALUE_W-1:0] i_entry_value,
    output pal_pkg::t_dp_stat             o_stat,
    output logic [pal_pkg::ST_W-1:0]      o_status,
    output logic [pal_pkg::EC_W-1:0]      o_entry_count,
    output logic [pal_pkg::NAME_W-1:0]    o_read_name,
    output logic [pal_pkg::VALUE_W-1:0]   o_read_value
);
    import pal_pkg::*;

    // Captured request
    logic               r_hold;
    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_pos;
    logic [NAME_W-1:0]  r_name;
    logic [VALUE_W-1:0] r_value;

    // List cells and fill count
    logic [NAME_W-1:0]  r_names  [CAPACITY];
    logic [VALUE_W-1:0] r_values [CAPACITY];
    logic [CNT_W-1:0]   r_count, n_count;

    // Result registers
    logic [ST_W-1:0]    r_status, n_status;
    logic [NAME_W-1:0]  r_rd_name, n_rd_name;
    logic [VALUE_W-1:0] r_rd_value, n_rd_value;

    logic [EC_W-1:0]    pos_x;
    logic [EC_W-1:0]    cnt_x;
    logic               do_ins;
    logic               do_rem;

    assign pos_x = EC_W'(r_pos);
    assign cnt_x = EC_W'(r_count);

    // Hold the request until it executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else if (i_cmd.load) begin
            r_hold <= 1'b1;
        end else if (i_cmd.exec) begin
            r_hold <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_pos   <= i_position;
            r_name  <= i_entry_name;
            r_value <= i_entry_value;
        end
    end

    // Decide outcome of the held request
    always_comb begin
        n_status   = ST_BADPOS;
        n_count    = r_count;
        n_rd_name  = '0;
        n_rd_value = '0;
        do_ins     = 1'b0;
        do_rem     = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (cnt_x >= EC_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else if (pos_x > cnt_x) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count + CNT_W'(1);
                    do_ins   = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count - CNT_W'(1);
                    do_rem   = 1'b1;
                end
            end
            OP_READ: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_status   = ST_DONE;
                    n_rd_name  = r_names[r_pos[IDX_W-1:0]];
                    n_rd_value = r_values[r_pos[IDX_W-1:0]];
                end
            end
            default: n_status = ST_BADPOS;
        endcase
    end

    // Shift each cell from its neighbor on insert or remove; insert also writes the new entry
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [EC_W-1:0] IDX = EC_W'(gi);
        always_ff @(posedge i_clk) begin
            if (i_cmd.exec && do_ins) begin
                if (IDX == pos_x) begin
                    r_names[gi]  <= r_name;
                    r_values[gi] <= r_value;
                end else if (IDX > pos_x && IDX <= cnt_x) begin
                    if (gi > 0) begin
                        r_names[gi]  <= r_names[(gi > 0) ? gi - 1 : 0];
                        r_values[gi] <= r_values[(gi > 0) ? gi - 1 : 0];
                    end
                end
            end else if (i_cmd.exec && do_rem) begin
                if (IDX >= pos_x && (IDX + EC_W'(1)) < cnt_x) begin
                    if (gi < CAPACITY - 1) begin
                        r_names[gi]  <= r_names[(gi < CAPACITY - 1) ? gi + 1 : gi];
                        r_values[gi] <= r_values[(gi < CAPACITY - 1) ? gi + 1 : gi];
                    end
                end
            end
        end
    end

    // Update count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_rd_name  <= n_rd_name;
            r_rd_value <= n_rd_value;
        end
    end

    assign o_stat.holding = r_hold;
    assign o_status       = r_status;
    assign o_entry_count  = EC_W'(r_count);
    assign o_read_name    = r_rd_name;
    assign o_read_value   = r_rd_value;

endmodule

`default_nettype wire

FILE: rtl/core/positional_array_list.sv
`default_nettype none

// Ordered list of up to CAPACITY entries (8), each a 64-bit name and 32-bit
// value, held in register cells that shift in parallel.
// Request channel: raise i_start with i_opcode, i_position, i_entry_name and
// i_entry_value; the request is taken at a rising edge where i_start is high
// and o_busy is low. Opcodes: insert at position, remove at position, read.
// Result channel: o_done pulses for one cycle with o_status, o_entry_count,
// o_read_name and o_read_value. There is no back-pressure: the result must
// be captured in that cycle.
// The block first captures the request, then in the execute cycle checks the
// position against the count and shifts all cells at once; o_done and the
// result are registered at the end of that cycle. A new request is taken only
// once the execute cycle is over. o_busy is high in the execute cycle only.
// Reset (i_rst_n low, synchronous) empties the list and clears the control
// state; the entry cells keep their contents, which are never read until
// they are written again.

module positional_array_list (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pal_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [pal_pkg::POS_W-1:0]   i_position,
    input  wire logic [pal_pkg::NAME_W-1:0]  i_entry_name,
    input  wire logic [pal_pkg::VALUE_W-1:0] i_entry_value,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [pal_pkg::ST_W-1:0]         o_status,
    output logic [pal_pkg::EC_W-1:0]         o_entry_count,
    output logic [pal_pkg::NAME_W-1:0]       o_read_name,
    output logic [pal_pkg::VALUE_W-1:0]      o_read_value
);
    import pal_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // Sequence requests
    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Hold the list and compute results
    pal_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_entry_name  (i_entry_name),
        .i_entry_value (i_entry_value),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_name   (o_read_name),
        .o_read_value  (o_read_value)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pal_checker.sv
`default_nettype none

module pal_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_start,
    input wire logic                        o_busy,
    input wire logic                        o_done,
    input wire logic [pal_pkg::ST_W-1:0]    o_status,
    input wire logic [pal_pkg::EC_W-1:0]    o_entry_count,
    input wire logic [pal_pkg::NAME_W-1:0]  o_read_name,
    input wire logic [pal_pkg::VALUE_W-1:0] o_read_value
);
    import pal_pkg::*;

    // Each accepted request yields a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_done)
        else $error("request produced no result");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without a preceding execute cycle");

    // A refused request leaves the count unchanged
    a_refused_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 2) && o_status != ST_DONE)
            |-> o_entry_count == $past(o_entry_count, 2))
        else $error("refused request changed the count");

    // A refused request returns no entry data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_read_name == '0 && o_read_value == '0))
        else $error("read fields nonzero on refused request");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= EC_W'(CAPACITY))
        else $error("count beyond capacity");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_read_name   (o_read_name),
    .o_read_value  (o_read_value)
);

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;
    import pal_pkg::*;

    // Unused opcode code point, answered as a no-op with invalid position
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int RANDOM_ITEMS  = 500;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 200000;

    typedef struct {
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   position;
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
    } list_request_t;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic [EC_W-1:0]    count;
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
    } list_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_start       = 1'b0;
    logic [OP_W-1:0]     i_opcode      = '0;
    logic [POS_W-1:0]    i_position    = '0;
    logic [NAME_W-1:0]   i_entry_name  = '0;
    logic [VALUE_W-1:0]  i_entry_value = '0;
    logic                o_busy;
    logic                o_done;
    logic [ST_W-1:0]     o_status;
    logic [EC_W-1:0]     o_entry_count;
    logic [NAME_W-1:0]   o_read_name;
    logic [VALUE_W-1:0]  o_read_value;

    positional_array_list u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_entry_name  (i_entry_name),
        .i_entry_value (i_entry_value),
        .o_busy        (o_busy),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_read_name   (o_read_name),
        .o_read_value  (o_read_value)
    );

    always #6 i_clk = ~i_clk;

    list_request_t pending_requests[$];
    list_result_t  predicted_results[$];
    int unsigned   mismatch_count = 0;
    int unsigned   gen_count = 0;

    // Shadow copy of the list, updated as each request is accepted
    logic [NAME_W-1:0]  shadow_names  [CAPACITY];
    logic [VALUE_W-1:0] shadow_values [CAPACITY];
    int unsigned        shadow_count = 0;

    // Apply one request to the shadow list and return the answer it earns
    function automatic list_result_t apply_list_request(input list_request_t rq);
        list_result_t rs;
        int unsigned  pos;
        int unsigned  i;
        rs.status = ST_BADPOS;
        rs.name   = '0;
        rs.value  = '0;
        pos = rq.position;
        case (rq.opcode)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else if (pos <= shadow_count) begin
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_names[i]  = shadow_names[i-1];
                        shadow_values[i] = shadow_values[i-1];
                    end
                    shadow_names[pos]  = rq.name;
                    shadow_values[pos] = rq.value;
                    shadow_count++;
                    rs.status = ST_DONE;
                end
            end
            OP_REMOVE: begin
                if (shadow_count == 0) begin
                    rs.status = ST_EMPTY;
                end else if (pos < shadow_count) begin
                    for (i = pos; i + 1 < shadow_count; i++) begin
                        shadow_names[i]  = shadow_names[i+1];
                        shadow_values[i] = shadow_values[i+1];
                    end
                    shadow_count--;
                    rs.status = ST_DONE;
                end
            end
            OP_READ: begin
                if (shadow_count == 0) begin
                    rs.status = ST_EMPTY;
                end else if (pos < shadow_count) begin
                    rs.name   = shadow_names[pos];
                    rs.value  = shadow_values[pos];
                    rs.status = ST_DONE;
                end
            end
            default: begin
                rs.status = ST_BADPOS;
            end
        endcase
        rs.count = EC_W'(shadow_count);
        return rs;
    endfunction

    // Queue one request and track the list size it leaves behind
    task automatic queue_request(input logic [OP_W-1:0] op, input int unsigned pos,
                                 input logic [NAME_W-1:0] nm, input logic [VALUE_W-1:0] val);
        list_request_t rq;
        rq.opcode   = op;
        rq.position = POS_W'(pos);
        rq.name     = nm;
        rq.value    = val;
        pending_requests.push_back(rq);
        if (op == OP_INSERT && gen_count < CAPACITY && rq.position <= gen_count)
            gen_count++;
        else if (op == OP_REMOVE && gen_count > 0 && rq.position < gen_count)
            gen_count--;
    endtask

    // Build the directed and random request streams
    initial begin
        int unsigned   n;
        int unsigned   roll;
        int unsigned   pos;
        int unsigned   fill_phase;
        logic [OP_W-1:0] op;
        // empty list corner cases
        queue_request(OP_READ,   0,  {$urandom, $urandom}, $urandom);
        queue_request(OP_REMOVE, 0,  {$urandom, $urandom}, $urandom);
        queue_request(OP_NONE,   0,  {$urandom, $urandom}, $urandom);
        queue_request(OP_INSERT, 1,  {$urandom, $urandom}, $urandom);
        queue_request(OP_INSERT, 63, {$urandom, $urandom}, $urandom);
        // fill: first, append, front, middle, to capacity, then one insert too many
        queue_request(OP_INSERT, 0, '1, '1);
        queue_request(OP_INSERT, 1, '0, '0);
        queue_request(OP_INSERT, 0, {$urandom, $urandom}, $urandom);
        queue_request(OP_INSERT, 1, {$urandom, $urandom}, $urandom);
        while (gen_count < CAPACITY)
            queue_request(OP_INSERT, gen_count, {$urandom, $urandom}, $urandom);
        queue_request(OP_INSERT, 0, {$urandom, $urandom}, $urandom);
        // reads on a full list, in and out of range
        queue_request(OP_READ, 0,            '0, '0);
        queue_request(OP_READ, CAPACITY - 1, '0, '0);
        queue_request(OP_READ, CAPACITY,     '0, '0);
        queue_request(OP_READ, 63,           '0, '0);
        // removes: out of range, middle, last, first
        queue_request(OP_REMOVE, 63, '0, '0);
        queue_request(OP_REMOVE, 3,  '0, '0);
        queue_request(OP_REMOVE, gen_count - 1, '0, '0);
        queue_request(OP_REMOVE, 0,  '0, '0);
        queue_request(OP_NONE,   63, '1, '1);
        queue_request(OP_READ,   2,  '0, '0);

        // Random part: pick a fill or drain phase every 40 items so both ends are reached
        fill_phase = 1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                fill_phase = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                op  = OP_W'($urandom_range(0, 3));
                pos = $urandom_range(0, 63);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < (fill_phase ? 65 : 20))
                    op = OP_INSERT;
                else if (roll < 85)
                    op = OP_REMOVE;
                else
                    op = OP_READ;
                if ($urandom_range(0, 9) < 9) begin
                    if (op == OP_INSERT)
                        pos = $urandom_range(0, gen_count);
                    else
                        pos = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
                end else begin
                    pos = $urandom_range(0, CAPACITY + 1);
                end
            end
            queue_request(op, pos, {$urandom, $urandom}, $urandom);
        end
    end

    // Driver: present requests in bursts, hold each until taken
    list_request_t cur_request;
    int unsigned   burst_left = 0;
    int unsigned   gap_left = 0;

    always @(posedge i_clk) begin
        logic         taken;
        list_result_t rs;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            taken = i_start && !o_busy;
            if (taken) begin
                rs = apply_list_request(cur_request);
                predicted_results.push_back(rs);
            end
            if (!i_start || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_request    = pending_requests.pop_front();
                    i_start       <= 1'b1;
                    i_opcode      <= cur_request.opcode;
                    i_position    <= cur_request.position;
                    i_entry_name  <= cur_request.name;
                    i_entry_value <= cur_request.value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        list_result_t exp_rs;
        if (i_rst_n && o_done) begin
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d count %0d name %h value %h",
                             o_status, o_entry_count, o_read_name, o_read_value);
            end else begin
                exp_rs = predicted_results.pop_front();
                if (o_status !== exp_rs.status || o_entry_count !== exp_rs.count ||
                    o_read_name !== exp_rs.name || o_read_value !== exp_rs.value) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected status %0d count %0d name %h value %h, got status %0d count %0d name %h value %h",
                                 exp_rs.status, exp_rs.count, exp_rs.name, exp_rs.value,
                                 o_status, o_entry_count, o_read_name, o_read_value);
                end
            end
        end
    end

    // Reset, then wait for every request to be taken and answered
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(posedge i_clk);
        while (pending_requests.size() != 0 || i_start || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * LIMIT_CYCLES);
        $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
